// ===== rtl/core/lpas_pkg.sv =====
// shared types and constants for the long-press action selector
`default_nettype none
package lpas_pkg;

	// slot configuration
	localparam int ACTION_SLOTS = 4;
	localparam int HOLD_REGS    = 4;
	localparam int SLOT_CAP     = (ACTION_SLOTS < HOLD_REGS) ? ACTION_SLOTS : HOLD_REGS;
	localparam int SLOT_W       = 2;

	// field widths
	localparam int TIME_W   = 32;
	localparam int IVAL_W   = 16;
	localparam int COUNT_W  = 3;
	localparam int ENABLE_W = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// long hold that cancels a pending action
	localparam logic [TIME_W-1:0] CANCEL_HOLD_MS = 32'd60000;

	// reset value of the interval register
	localparam logic [IVAL_W-1:0] INTERVAL_RST = 16'd1000;

	// remainder unit: one quotient bit per cycle
	localparam int DIV_STEPS = TIME_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD0    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD1    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD2    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD3    = 3'd6;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EVAL = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} lpas_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic div_init;
		logic div_step;
		logic commit;
	} lpas_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rep_hit;
		logic out_free;
	} lpas_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/lpas_ctrl.sv =====
// controller state machine for the long-press action selector
`default_nettype none
module lpas_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  lpas_pkg::lpas_sts_t  sts,
	output lpas_pkg::lpas_cmd_t  cmd
);
	import lpas_pkg::*;

	lpas_state_t          state_q;
	lpas_state_t          state_nxt;
	logic [DIV_CNT_W-1:0] cnt_q;

	assign in_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_nxt    = state_q;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.rep_hit) begin
					cmd.div_init = 1'b1;
					state_nxt    = ST_DIV;
				end else begin
					state_nxt = ST_FIN;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (cmd.div_init) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/lpas_dp.sv =====
// datapath: registers, hold timing, remainder unit, slot selection, result register
`default_nettype none
module lpas_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  lpas_pkg::lpas_cmd_t                      cmd,
	output lpas_pkg::lpas_sts_t                      sts,
	input  wire logic                                cfg_we,
	input  wire logic [lpas_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [lpas_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  wire logic [lpas_pkg::TIME_W-1:0]         now_ms,
	input  wire logic                                key_level,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     repeat_valid,
	output logic [lpas_pkg::TIME_W-1:0]              held_block_ms,
	output logic                                     key_released,
	output logic                                     action_valid,
	output logic [lpas_pkg::SLOT_W-1:0]              action_index
);
	import lpas_pkg::*;

	// configuration registers
	logic [IVAL_W-1:0]   interval_q;
	logic [COUNT_W-1:0]  count_q;
	logic [ENABLE_W-1:0] enable_q;
	logic [IVAL_W-1:0]   hold_time_q [HOLD_REGS];

	// tick state
	logic              key_held_q;
	logic [TIME_W-1:0] press_start_q;
	logic [TIME_W-1:0] hold_q;
	logic [TIME_W-1:0] trig_q;
	logic              pend_valid_q;
	logic [SLOT_W-1:0] pend_slot_q;

	// remainder unit
	logic [TIME_W-1:0] dvd_q;
	logic [IVAL_W-1:0] rem_q;
	logic [IVAL_W:0]   rem_sh;
	logic [IVAL_W:0]   rem_sub;

	// output register
	logic              out_valid_q;
	logic              rep_out_q;
	logic [TIME_W-1:0] block_out_q;
	logic              rel_out_q;
	logic              act_out_q;
	logic [SLOT_W-1:0] aidx_out_q;

	logic [IVAL_W-1:0]  ival_eff;
	logic [COUNT_W-1:0] slots_n;
	logic               pressed;
	logic               rep_hit;
	logic [TIME_W-1:0]  block;
	logic               pv_sel;
	logic [SLOT_W-1:0]  ps_sel;
	logic               pv_cut;
	logic               fire;

	assign ival_eff = (interval_q == '0) ? IVAL_W'(1) : interval_q;
	assign slots_n  = (count_q > COUNT_W'(SLOT_CAP)) ? COUNT_W'(SLOT_CAP) : count_q;
	assign pressed  = ~key_level;

	// repeat trigger check on the stored hold time
	assign rep_hit = (hold_q != '0) && (hold_q >= trig_q);

	assign sts.rep_hit  = rep_hit;
	assign sts.out_free = ~out_valid_q | out_ready;

	// restoring remainder step
	assign rem_sh  = {rem_q, dvd_q[TIME_W-1]};
	assign rem_sub = rem_sh - {1'b0, ival_eff};

	assign block = hold_q - {{(TIME_W-IVAL_W){1'b0}}, rem_q};

	// slot selection, cancel and release
	always_comb begin
		pv_sel = pend_valid_q;
		ps_sel = pend_slot_q;
		if (rep_hit) begin
			for (int a = 0; a < HOLD_REGS; a++) begin
				if ((a < int'(slots_n)) && (hold_time_q[a] != '0) &&
				    (block == {{(TIME_W-IVAL_W){1'b0}}, hold_time_q[a]})) begin
					pv_sel = 1'b1;
					ps_sel = SLOT_W'(a);
				end
			end
			if (hold_q >= CANCEL_HOLD_MS) begin
				pv_sel = 1'b0;
			end
		end
		pv_cut = pv_sel;
		fire   = 1'b0;
		if (!key_held_q && pv_sel && enable_q[ps_sel]) begin
			fire   = 1'b1;
			pv_cut = 1'b0;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RST;
			count_q    <= '0;
			enable_q   <= '0;
			for (int i = 0; i < HOLD_REGS; i++) begin
				hold_time_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INTERVAL: interval_q     <= cfg_wdata[IVAL_W-1:0];
				REG_COUNT:    count_q        <= cfg_wdata[COUNT_W-1:0];
				REG_ENABLE:   enable_q       <= cfg_wdata[ENABLE_W-1:0];
				REG_HOLD0:    hold_time_q[0] <= cfg_wdata[IVAL_W-1:0];
				REG_HOLD1:    hold_time_q[1] <= cfg_wdata[IVAL_W-1:0];
				REG_HOLD2:    hold_time_q[2] <= cfg_wdata[IVAL_W-1:0];
				REG_HOLD3:    hold_time_q[3] <= cfg_wdata[IVAL_W-1:0];
				default: ;
			endcase
		end
	end

	// tick state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_held_q    <= 1'b0;
			press_start_q <= '0;
			hold_q        <= '0;
			trig_q        <= '0;
			pend_valid_q  <= 1'b0;
			pend_slot_q   <= '0;
		end else if (cmd.load) begin
			if (pressed) begin
				key_held_q <= 1'b1;
				if (!key_held_q) begin
					press_start_q <= now_ms;
					trig_q        <= {{(TIME_W-IVAL_W){1'b0}}, ival_eff};
					hold_q        <= '0;
				end else begin
					hold_q <= now_ms - press_start_q;
				end
			end else begin
				key_held_q <= 1'b0;
			end
		end else if (cmd.commit) begin
			if (rep_hit) begin
				trig_q <= block + {{(TIME_W-IVAL_W){1'b0}}, ival_eff};
			end
			if (!key_held_q) begin
				hold_q <= '0;
			end
			pend_valid_q <= pv_cut;
			pend_slot_q  <= ps_sel;
		end
	end

	// remainder unit
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			dvd_q <= hold_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[TIME_W-2:0], 1'b0};
			rem_q <= rem_sub[IVAL_W] ? rem_sh[IVAL_W-1:0] : rem_sub[IVAL_W-1:0];
		end
	end

	// result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rep_out_q   <= rep_hit;
			block_out_q <= rep_hit ? block : '0;
			rel_out_q   <= ~key_held_q;
			act_out_q   <= fire;
			aidx_out_q  <= fire ? ps_sel : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign repeat_valid  = rep_out_q;
	assign held_block_ms = block_out_q;
	assign key_released  = rel_out_q;
	assign action_valid  = act_out_q;
	assign action_index  = aidx_out_q;

endmodule
`default_nettype wire

// ===== rtl/core/long_press_action_selector_core.sv =====
// Long-press action selector: one result beat per input beat.
// Each beat is loaded and evaluated; on a repeat the hold time goes through
// the bit-serial remainder unit, then the result is committed to the output
// register once it is free. A new input beat is taken only after the last is
// committed; a result waiting in the output register does not block it.
// Reset: arst_n resets all state but the remainder unit and output data registers.
`default_nettype none
module long_press_action_selector_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [lpas_pkg::TIME_W-1:0]         now_ms,
	input  wire logic                                key_level,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     repeat_valid,
	output logic [lpas_pkg::TIME_W-1:0]              held_block_ms,
	output logic                                     key_released,
	output logic                                     action_valid,
	output logic [lpas_pkg::SLOT_W-1:0]              action_index,
	input  wire logic                                cfg_we,
	input  wire logic [lpas_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [lpas_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import lpas_pkg::*;

	lpas_cmd_t cmd;
	lpas_sts_t sts;

	lpas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpas_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.now_ms        (now_ms),
		.key_level     (key_level),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.repeat_valid  (repeat_valid),
		.held_block_ms (held_block_ms),
		.key_released  (key_released),
		.action_valid  (action_valid),
		.action_index  (action_index)
	);

	// an action only fires on a key-up beat
	a_fire_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action_valid |-> key_released)
		else $error("action fired while key held");

	// block value is zero without a repeat event
	a_block_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !repeat_valid |-> held_block_ms == '0)
		else $error("held block nonzero without repeat");

	// slot index is zero without an action
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !action_valid |-> action_index == '0)
		else $error("action index nonzero without action");

	// one item in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second beat taken while item in flight");

endmodule
`default_nettype wire
